@@ rtl/ctf_pkg.sv @@
// Shared types and constants for the IMU tilt complementary filter.
// Holds the payload structs, the sequencer phases and the arctangent table.
// No dependencies.
package ctf_pkg;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic        [15:0] step_us;
	} imu_in_t;

	typedef struct packed {
		logic signed [31:0] roll_deg;
		logic signed [31:0] pitch_deg;
		logic               accel_blended;
	} imu_out_t;

	typedef enum logic [1:0] {
		CFG_BLEND_GAIN    = 2'd0,
		CFG_INITIAL_STEP  = 2'd1,
		CFG_GRAVITY_LEVEL = 2'd2,
		CFG_GRAVITY_BAND  = 2'd3
	} cfg_reg_t;

	typedef enum logic [4:0] {
		PH_IDLE,
		PH_GR_MUL,
		PH_GR_DIV,
		PH_GP_MUL,
		PH_GP_DIV,
		PH_SQ_X,
		PH_SQ_Y,
		PH_SQ_Z,
		PH_SQ_LO,
		PH_SQ_HI,
		PH_SQRT,
		PH_CR_ROLL,
		PH_CR_PITCH,
		PH_BL_RG,
		PH_BL_RA,
		PH_BL_PG,
		PH_BL_PA,
		PH_WB
	} phase_t;

	localparam logic [15:0] BLEND_GAIN_RST    = 16'd62259;
	localparam logic [15:0] INITIAL_STEP_RST  = 16'd1000;
	localparam logic [14:0] GRAVITY_LEVEL_RST = 15'd2509;
	localparam logic [14:0] GRAVITY_BAND_RST  = 15'd128;

	// Serial multiplier operand widths.
	localparam int MUL_AW = 32;
	localparam int MUL_BW = 17;

	// Division by one million with rounding, one quotient bit per cycle.
	localparam int DIV_NW = 45;
	localparam int DIV_QW = 25;
	localparam int DIV_RW = 20;
	localparam logic [DIV_RW:0]   DIV_K    = 21'd1000000;
	localparam logic [DIV_NW-1:0] DIV_HALF = 45'd500000;

	localparam int SQ_IN_W  = 48;
	localparam int SQ_OUT_W = 24;

	localparam int CRD_IN_W = 26;
	localparam int CRD_W    = 44;
	localparam int ATAN_LEN = 24;
	localparam int ATAN_W   = 22;
	localparam logic signed [31:0] DEG180 = 32'sd11796480;

	// atan(2^-i) in Q16.16 degrees.
	localparam logic [ATAN_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
		22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
	};

endpackage

@@ rtl/imu_tilt_complementary_filter_unit.sv @@
// Roll and pitch complementary filter for one IMU sample per transaction. A sequencer runs
// every product through one bit-serial 32x17 multiplier, the gyro increments through a
// one-bit-per-cycle divider, and the tilt angles through an iterative square root and
// CORDIC (twice). A sample outside the gravity band skips the square root, CORDIC and
// blend phases and runs seven serial products; a blended sample runs all eleven. One sample
// is processed at a time; the next is taken as soon as the result is in the output register.
module imu_tilt_complementary_filter_unit #(
	parameter int CORDIC_ITERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  ctf_pkg::imu_in_t  sample,
	output logic              result_valid,
	input  logic              result_stall,
	output ctf_pkg::imu_out_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import ctf_pkg::*;

	function automatic logic [15:0] abs16(input logic [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? 32'(-v) : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		if (v > 51'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -51'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return $signed(v[31:0]);
		end
	endfunction

	logic [15:0]        blend_gain_q;
	logic [15:0]        init_step_q;
	logic [14:0]        grav_level_q;
	logic [14:0]        grav_band_q;
	logic [15:0]        step_time_q;
	logic signed [31:0] roll_q;
	logic signed [31:0] pitch_q;
	logic signed [15:0] prev_rx_q;
	logic signed [15:0] prev_ry_q;
	imu_in_t            smp_q;
	phase_t             phase_q;
	phase_t             phase_d;
	logic               start_q;

	logic               mul_start;
	logic               div_start;
	logic               sqrt_start;
	logic               crd_start;
	logic               mul_done;
	logic               div_done;
	logic               sqrt_done;
	logic               crd_done;
	logic [MUL_AW-1:0]  mul_a;
	logic [MUL_BW-1:0]  mul_b;
	logic               mul_neg;
	logic [MUL_AW+MUL_BW-1:0] mul_prod;
	logic signed [50:0] mul_sprod;
	logic [31:0]        mag_q;
	logic [DIV_NW-1:0]  div_num;
	logic [DIV_QW-1:0]  div_quo;
	logic [SQ_OUT_W-1:0] sqrt_root;
	logic signed [CRD_IN_W-1:0] crd_y;
	logic signed [CRD_IN_W-1:0] crd_x;
	logic signed [31:0] crd_angle;

	logic signed [16:0] sum_rx;
	logic signed [16:0] sum_ry;
	logic signed [16:0] s_sel;
	logic [16:0]        s_abs;
	logic               roll_axis;
	logic signed [31:0] angle_sel;
	logic signed [50:0] gyro_inc;
	logic signed [50:0] gyro_sum;
	logic signed [50:0] blend_sum;
	logic signed [31:0] gyro_new;
	logic signed [31:0] blend_new;
	logic signed [15:0] lo_s;
	logic [15:0]        hi_u;
	logic [31:0]        sq_x_q;
	logic [31:0]        sq_y_q;
	logic [31:0]        yz_q;
	logic [31:0]        lo2_q;
	logic [32:0]        sum_q;
	logic               inside_now;
	logic               inside_q;
	logic signed [31:0] g_roll_q;
	logic signed [31:0] g_pitch_q;
	logic signed [31:0] a_roll_q;
	logic signed [31:0] a_pitch_q;
	logic signed [31:0] b_roll_q;
	logic signed [31:0] b_pitch_q;
	logic signed [50:0] acc_q;
	logic               accept;
	logic               wb_fire;
	imu_out_t           result_q;
	logic               result_valid_q;

	// Units.
	ctf_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ctf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.done   (div_done),
		.quo    (div_quo)
	);

	ctf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({yz_q, 16'b0}),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	ctf_cordic #(.ITERS(CORDIC_ITERS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crd_start),
		.y_in   (crd_y),
		.x_in   (crd_x),
		.done   (crd_done),
		.angle  (crd_angle)
	);

	// Gyro path: trapezoid sum of the two rates, scaled by the step time.
	assign sum_rx    = $signed({smp_q.rate_x[15], smp_q.rate_x}) + $signed({prev_rx_q[15], prev_rx_q});
	assign sum_ry    = $signed({smp_q.rate_y[15], smp_q.rate_y}) + $signed({prev_ry_q[15], prev_ry_q});
	assign roll_axis = (phase_q == PH_GR_MUL) || (phase_q == PH_GR_DIV);
	assign s_sel     = roll_axis ? sum_rx : sum_ry;
	assign s_abs     = s_sel[16] ? 17'(-s_sel) : 17'(s_sel);
	assign angle_sel = roll_axis ? roll_q : pitch_q;
	assign div_num   = {2'b00, mag_q, 11'b0} + DIV_HALF;
	assign gyro_inc  = s_sel[16] ? -$signed({26'b0, div_quo}) : $signed({26'b0, div_quo});
	assign gyro_sum  = 51'(angle_sel) + gyro_inc;
	assign gyro_new  = sat32(gyro_sum);

	assign mul_sprod = mul_neg ? -$signed({2'b00, mul_prod}) : $signed({2'b00, mul_prod});
	assign blend_sum = acc_q + mul_sprod + 51'sd32768;
	assign blend_new = sat32(blend_sum >>> 16);

	assign lo_s = $signed({1'b0, grav_level_q}) - $signed({1'b0, grav_band_q});
	assign hi_u = {1'b0, grav_level_q} + {1'b0, grav_band_q};

	// A negative lower bound always passes; the upper square arrives from the multiplier.
	assign inside_now = (lo_s[15] || (sum_q > {1'b0, lo2_q})) && (sum_q < {1'b0, mul_prod[31:0]});

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (phase_q)
			PH_GR_MUL, PH_GP_MUL: begin
				mul_a = {16'b0, step_time_q};
				mul_b = s_abs;
			end
			PH_SQ_X: begin
				mul_a = {16'b0, abs16(smp_q.accel_x)};
				mul_b = {1'b0, abs16(smp_q.accel_x)};
			end
			PH_SQ_Y: begin
				mul_a = {16'b0, abs16(smp_q.accel_y)};
				mul_b = {1'b0, abs16(smp_q.accel_y)};
			end
			PH_SQ_Z: begin
				mul_a = {16'b0, abs16(smp_q.accel_z)};
				mul_b = {1'b0, abs16(smp_q.accel_z)};
			end
			PH_SQ_LO: begin
				mul_a = {16'b0, lo_s};
				mul_b = {1'b0, lo_s};
			end
			PH_SQ_HI: begin
				mul_a = {16'b0, hi_u};
				mul_b = {1'b0, hi_u};
			end
			PH_BL_RG: begin
				mul_a   = abs32(g_roll_q);
				mul_b   = {1'b0, blend_gain_q};
				mul_neg = g_roll_q[31];
			end
			PH_BL_RA: begin
				mul_a   = abs32(a_roll_q);
				mul_b   = 17'h10000 - {1'b0, blend_gain_q};
				mul_neg = a_roll_q[31];
			end
			PH_BL_PG: begin
				mul_a   = abs32(g_pitch_q);
				mul_b   = {1'b0, blend_gain_q};
				mul_neg = g_pitch_q[31];
			end
			PH_BL_PA: begin
				mul_a   = abs32(a_pitch_q);
				mul_b   = 17'h10000 - {1'b0, blend_gain_q};
				mul_neg = a_pitch_q[31];
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_comb begin
		if (phase_q == PH_CR_PITCH) begin
			crd_y = -$signed({{2{smp_q.accel_x[15]}}, smp_q.accel_x, 8'b0});
			crd_x = $signed({2'b00, sqrt_root});
		end else begin
			crd_y = $signed({{2{smp_q.accel_y[15]}}, smp_q.accel_y, 8'b0});
			crd_x = $signed({{2{smp_q.accel_z[15]}}, smp_q.accel_z, 8'b0});
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE:     if (sample_valid) phase_d = PH_GR_MUL;
			PH_GR_MUL:   if (mul_done) phase_d = PH_GR_DIV;
			PH_GR_DIV:   if (div_done) phase_d = PH_GP_MUL;
			PH_GP_MUL:   if (mul_done) phase_d = PH_GP_DIV;
			PH_GP_DIV:   if (div_done) phase_d = PH_SQ_X;
			PH_SQ_X:     if (mul_done) phase_d = PH_SQ_Y;
			PH_SQ_Y:     if (mul_done) phase_d = PH_SQ_Z;
			PH_SQ_Z:     if (mul_done) phase_d = PH_SQ_LO;
			PH_SQ_LO:    if (mul_done) phase_d = PH_SQ_HI;
			PH_SQ_HI:    if (mul_done) phase_d = inside_now ? PH_SQRT : PH_WB;
			PH_SQRT:     if (sqrt_done) phase_d = PH_CR_ROLL;
			PH_CR_ROLL:  if (crd_done) phase_d = PH_CR_PITCH;
			PH_CR_PITCH: if (crd_done) phase_d = PH_BL_RG;
			PH_BL_RG:    if (mul_done) phase_d = PH_BL_RA;
			PH_BL_RA:    if (mul_done) phase_d = PH_BL_PG;
			PH_BL_PG:    if (mul_done) phase_d = PH_BL_PA;
			PH_BL_PA:    if (mul_done) phase_d = PH_WB;
			PH_WB:       if (!result_valid_q || !result_stall) phase_d = PH_IDLE;
			default:     phase_d = PH_IDLE;
		endcase
	end

	// Phase outputs.
	always_comb begin
		mul_start  = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		crd_start  = 1'b0;
		wb_fire    = 1'b0;
		case (phase_q)
			PH_GR_MUL, PH_GP_MUL, PH_SQ_X, PH_SQ_Y, PH_SQ_Z, PH_SQ_LO, PH_SQ_HI,
			PH_BL_RG, PH_BL_RA, PH_BL_PG, PH_BL_PA: mul_start = start_q;
			PH_GR_DIV, PH_GP_DIV:                   div_start = start_q;
			PH_SQRT:                                sqrt_start = start_q;
			PH_CR_ROLL, PH_CR_PITCH:                crd_start = start_q;
			PH_WB:                                  wb_fire = !result_valid_q || !result_stall;
			default:                                wb_fire = 1'b0;
		endcase
	end

	assign sample_stall = (phase_q != PH_IDLE);
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_gain_q   <= BLEND_GAIN_RST;
			init_step_q    <= INITIAL_STEP_RST;
			grav_level_q   <= GRAVITY_LEVEL_RST;
			grav_band_q    <= GRAVITY_BAND_RST;
			step_time_q    <= INITIAL_STEP_RST;
			roll_q         <= '0;
			pitch_q        <= '0;
			prev_rx_q      <= '0;
			prev_ry_q      <= '0;
			phase_q        <= PH_IDLE;
			start_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			start_q <= (phase_d != phase_q);
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BLEND_GAIN:    blend_gain_q <= cfg_data;
					CFG_INITIAL_STEP: begin
						init_step_q <= cfg_data;
						step_time_q <= cfg_data;
					end
					CFG_GRAVITY_LEVEL: grav_level_q <= cfg_data[14:0];
					CFG_GRAVITY_BAND:  grav_band_q <= cfg_data[14:0];
					default:           blend_gain_q <= blend_gain_q;
				endcase
			end else if (accept && (sample.step_us != '0)) begin
				step_time_q <= sample.step_us;
			end
			if (wb_fire) begin
				roll_q         <= inside_q ? b_roll_q : g_roll_q;
				pitch_q        <= inside_q ? b_pitch_q : g_pitch_q;
				prev_rx_q      <= smp_q.rate_x;
				prev_ry_q      <= smp_q.rate_y;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= sample;
		end
		if (mul_done) begin
			case (phase_q)
				PH_GR_MUL, PH_GP_MUL: mag_q <= mul_prod[31:0];
				PH_SQ_X:              sq_x_q <= mul_prod[31:0];
				PH_SQ_Y:              sq_y_q <= mul_prod[31:0];
				PH_SQ_Z:              yz_q <= sq_y_q + mul_prod[31:0];
				PH_SQ_LO: begin
					lo2_q <= mul_prod[31:0];
					sum_q <= {1'b0, yz_q} + {1'b0, sq_x_q};
				end
				PH_SQ_HI:             inside_q <= inside_now;
				PH_BL_RG, PH_BL_PG:   acc_q <= mul_sprod;
				PH_BL_RA:             b_roll_q <= blend_new;
				PH_BL_PA:             b_pitch_q <= blend_new;
				default:              acc_q <= acc_q;
			endcase
		end
		if (div_done) begin
			if (phase_q == PH_GR_DIV) begin
				g_roll_q <= gyro_new;
			end else begin
				g_pitch_q <= gyro_new;
			end
		end
		if (crd_done) begin
			if (phase_q == PH_CR_ROLL) begin
				a_roll_q <= crd_angle;
			end else begin
				a_pitch_q <= crd_angle;
			end
		end
		if (wb_fire) begin
			result_q.roll_deg      <= inside_q ? b_roll_q : g_roll_q;
			result_q.pitch_deg     <= inside_q ? b_pitch_q : g_pitch_q;
			result_q.accel_blended <= inside_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ rtl/ctf_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Unsigned operands; uses no package.
module ctf_mul #(
	parameter int AW = 32,
	parameter int BW = 17
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic            done,
	output logic [AW+BW-1:0] prod
);
	localparam int CW = $clog2(BW + 1);
	localparam logic [CW-1:0] LAST = CW'(BW - 1);

	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] acc_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [AW:0]      hi_sum;

	// The multiplier sits in the low BW bits of the accumulator and shifts out.
	assign hi_sum = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {hi_sum, acc_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ rtl/ctf_div.sv @@
// Restoring divider by the constant one million, one quotient bit per cycle.
// Depends on ctf_pkg for widths and the divisor.
module ctf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ctf_pkg::DIV_NW-1:0]   num,
	output logic                         done,
	output logic [ctf_pkg::DIV_QW-1:0]   quo
);
	import ctf_pkg::*;

	localparam logic [4:0] LAST = 5'(DIV_QW - 1);

	logic [DIV_RW-1:0] rem_q;
	logic [DIV_QW-1:0] qd_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_RW:0]   trial;
	logic              ge;
	logic [DIV_RW:0]   diff;

	assign trial = {rem_q, qd_q[DIV_QW-1]};
	assign ge    = trial >= DIV_K;
	assign diff  = trial - DIV_K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper dividend bits always stay below the divisor, so they seed the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DIV_NW-1:DIV_QW];
			qd_q  <= num[DIV_QW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
			qd_q  <= {qd_q[DIV_QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = qd_q;

endmodule

@@ rtl/ctf_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on ctf_pkg for widths.
module ctf_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ctf_pkg::SQ_IN_W-1:0]   radicand,
	output logic                          done,
	output logic [ctf_pkg::SQ_OUT_W-1:0]  root
);
	import ctf_pkg::*;

	localparam logic [4:0] LAST = 5'(SQ_OUT_W - 1);

	logic [SQ_IN_W-1:0]  v_q;
	logic [SQ_OUT_W:0]   rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [4:0]          cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [SQ_OUT_W+2:0] cur;
	logic [SQ_OUT_W+2:0] trial;
	logic [SQ_OUT_W+2:0] diff;
	logic                ge;

	assign cur   = {rem_q, v_q[SQ_IN_W-1:SQ_IN_W-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = cur >= trial;
	assign diff  = cur - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder never exceeds twice the partial root, so it fits one bit over the root.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? diff[SQ_OUT_W:0] : cur[SQ_OUT_W:0];
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ rtl/ctf_cordic.sv @@
// Iterative CORDIC vectoring unit giving atan2 in Q16.16 degrees, one step per cycle.
// Depends on ctf_pkg for widths and the arctangent table.
module ctf_cordic #(
	parameter int ITERS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [ctf_pkg::CRD_IN_W-1:0] y_in,
	input  logic signed [ctf_pkg::CRD_IN_W-1:0] x_in,
	output logic                                done,
	output logic signed [31:0]                  angle
);
	import ctf_pkg::*;

	localparam int N  = (ITERS > ATAN_LEN) ? ATAN_LEN : ITERS;
	localparam int CW = $clog2(ATAN_LEN);
	localparam logic [CW-1:0] LAST = CW'(N - 1);

	logic signed [CRD_W-1:0]    x_q;
	logic signed [CRD_W-1:0]    y_q;
	logic signed [31:0]         z_q;
	logic                       zero_q;
	logic [CW-1:0]              cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic signed [CRD_W-1:0]    dx;
	logic signed [CRD_W-1:0]    dy;
	logic signed [31:0]         tab;
	logic                       y_pos;
	logic                       x_neg;
	logic signed [CRD_IN_W-1:0] xs;
	logic signed [CRD_IN_W-1:0] ys;

	assign dx    = y_q >>> cnt_q;
	assign dy    = x_q >>> cnt_q;
	assign tab   = $signed({{(32-ATAN_W){1'b0}}, ATAN_TAB[cnt_q]});
	assign y_pos = !y_q[CRD_W-1] && (y_q != '0);
	assign x_neg = x_in[CRD_IN_W-1];
	assign xs    = x_neg ? -x_in : x_in;
	assign ys    = x_neg ? -y_in : y_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// A vector in the left half plane is turned by 180 degrees before the iterations.
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == '0) && (y_in == '0);
			x_q    <= $signed({{(CRD_W-CRD_IN_W-16){xs[CRD_IN_W-1]}}, xs, 16'b0});
			y_q    <= $signed({{(CRD_W-CRD_IN_W-16){ys[CRD_IN_W-1]}}, ys, 16'b0});
			if (x_neg) begin
				z_q <= y_in[CRD_IN_W-1] ? -DEG180 : DEG180;
			end else begin
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_pos) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

	assign done  = done_q;
	assign angle = zero_q ? 32'sd0 : z_q;

endmodule

@@ rtl/ctf_checker.sv @@
// Port-level checks for the IMU tilt complementary filter, bound to the top level.
// Depends on ctf_pkg for the payload types.
module ctf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input ctf_pkg::imu_in_t  sample,
	input logic              result_valid,
	input logic              result_stall,
	input ctf_pkg::imu_out_t result
);
	import ctf_pkg::*;

	imu_in_t unused_sample;
	assign unused_sample = sample;

	// A waiting result holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// A sample transaction makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall |=> sample_stall)
		else $error("input not stalled after a sample was taken");

	// A new result only appears at the end of processing.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_stall))
		else $error("result appeared while idle");

	// Going idle means a result has been written.
	a_idle_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(sample_stall) |-> result_valid)
		else $error("block went idle without a result");

endmodule

bind imu_tilt_complementary_filter_unit ctf_checker u_ctf_checker (.*);

@@ tb/ctf_checker.sv @@
// Checker for the IMU tilt complementary filter: watches both channels, predicts each
// result from its own copy of the filter state and compares. Depends on ctf_pkg.
`timescale 1ns / 1ps
module ctf_scoreboard (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              sample_stall,
	input  ctf_pkg::imu_in_t  sample,
	input  logic              result_valid,
	input  logic              result_stall,
	input  ctf_pkg::imu_out_t result,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output int                fail_count,
	output int                pending,
	output int                blended_count
);
	import ctf_pkg::*;

	localparam int ITERS = 16;
	localparam longint ATN [0:23] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0
	};

	logic [15:0] gain_r, init_step_r, step_r;
	logic [14:0] level_r, band_r;
	longint roll_s, pitch_s, prx, pry;
	imu_out_t expected_q[$];

	function automatic longint shr(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint tilt_atan2(longint y, longint x);
		longint z, dx, dy;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		x *= 65536;
		y *= 65536;
		for (int i = 0; i < ITERS && i < 24; i++) begin
			dx = shr(y, i);
			dy = shr(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += ATN[i];
			end else begin
				x -= dx; y += dy; z -= ATN[i];
			end
		end
		return z;
	endfunction

	function automatic longint integrate(longint ang, longint r, longint p, longint st);
		longint s, q;
		s = r + p;
		q = ((s < 0 ? -s : s) * st * 2048 + 500000) / 1000000;
		return clamp32(ang + (s < 0 ? -q : q));
	endfunction

	function automatic longint mix(longint g, longint a, longint k);
		return clamp32(shr(g * k + a * (65536 - k) + 32768, 16));
	endfunction

	task automatic predict_sample(imu_in_t s);
		longint ax, ay, az, gr, gp, sq, lo, hi, den;
		logic in_band;
		imu_out_t e;
		ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
		if (s.step_us != 0) step_r = s.step_us;
		gr = integrate(roll_s, s.rate_x, prx, step_r);
		gp = integrate(pitch_s, s.rate_y, pry, step_r);
		sq = ax * ax + ay * ay + az * az;
		lo = longint'(level_r) - longint'(band_r);
		hi = longint'(level_r) + longint'(band_r);
		in_band = (lo < 0 || sq > lo * lo) && sq < hi * hi;
		if (in_band) begin
			den = root(longint'(ay * ay + az * az) << 16);
			roll_s = mix(gr, tilt_atan2(ay * 256, az * 256), gain_r);
			pitch_s = mix(gp, tilt_atan2(-ax * 256, den), gain_r);
		end else begin
			roll_s = gr;
			pitch_s = gp;
		end
		prx = s.rate_x;
		pry = s.rate_y;
		e.roll_deg = roll_s[31:0];
		e.pitch_deg = pitch_s[31:0];
		e.accel_blended = in_band;
		expected_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		imu_out_t e;
		if (!arst_n) begin
			gain_r <= BLEND_GAIN_RST; init_step_r <= INITIAL_STEP_RST;
			step_r <= INITIAL_STEP_RST; level_r <= GRAVITY_LEVEL_RST;
			band_r <= GRAVITY_BAND_RST;
			roll_s = 0; pitch_s = 0; prx = 0; pry = 0;
			expected_q.delete();
			fail_count <= 0; pending <= 0; blended_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_BLEND_GAIN: gain_r = cfg_data;
					CFG_INITIAL_STEP: begin
						init_step_r = cfg_data;
						step_r = cfg_data;
					end
					CFG_GRAVITY_LEVEL: level_r = cfg_data[14:0];
					CFG_GRAVITY_BAND: band_r = cfg_data[14:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) predict_sample(sample);
			if (result_valid && !result_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (result.accel_blended) blended_count <= blended_count + 1;
					if (e.roll_deg !== result.roll_deg || e.pitch_deg !== result.pitch_deg
							|| e.accel_blended !== result.accel_blended) begin
						$display("%0t: expected roll %0d pitch %0d blend %0b, got %0d %0d %0b",
							$time, e.roll_deg, e.pitch_deg, e.accel_blended,
							result.roll_deg, result.pitch_deg, result.accel_blended);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

@@ tb/tb_imu_tilt_complementary_filter_unit.sv @@
// Top of the filter testbench: clock, reset, stimulus, configuration and verdict.
// Depends on ctf_pkg, the filter unit and ctf_scoreboard.
`timescale 1ns / 1ps
module tb_imu_tilt_complementary_filter_unit;
	import ctf_pkg::*;

	logic clk = 0, arst_n = 0;
	logic sample_valid = 0, result_stall = 0, cfg_we = 0;
	logic sample_stall, result_valid;
	imu_in_t sample = '0;
	imu_out_t result;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int fail_count, pending, blended_count;
	int cycles = 0, sent = 0;
	int stall_mode = 0;
	localparam int LIMIT = 4000000;

	always #4 clk = ~clk;

	imu_tilt_complementary_filter_unit dut (.*);
	ctf_scoreboard chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver stalls in changing modes: none, light, heavy.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			default: result_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send(imu_in_t s);
		sample <= s;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic pause_gap();
		sample_valid <= 1'b0;
		repeat ($urandom_range(0, 300)) @(negedge clk);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0 || sample_stall) @(posedge clk);
		repeat (400) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic imu_in_t rand_sample(logic level_like);
		imu_in_t s;
		int g;
		s = imu_in_t'(112'({$urandom, $urandom, $urandom, $urandom}));
		if (level_like) begin
			// Mostly near gravity so blending is exercised.
			g = $urandom_range(0, 2);
			s.accel_x = 16'($signed($urandom_range(0, 1200)) - 600);
			s.accel_y = 16'($signed($urandom_range(0, 1200)) - 600);
			s.accel_z = 16'($signed($urandom_range(0, 1200)) - 600);
			if (g == 0) s.accel_z = $urandom_range(0, 1) ? 16'sd2509 : -16'sd2509;
			else if (g == 1) s.accel_y = $urandom_range(0, 1) ? 16'sd2400 : -16'sd2400;
			else s.accel_x = $urandom_range(0, 1) ? 16'sd2300 : -16'sd2300;
			s.rate_x = 16'($signed($urandom_range(0, 4000)) - 2000);
			s.rate_y = 16'($signed($urandom_range(0, 4000)) - 2000);
			if ($urandom_range(0, 2) != 0) s.step_us = 0;
		end
		return s;
	endfunction

	function automatic imu_in_t mk(int ax, int ay, int az, int rx, int ry, int st);
		imu_in_t s;
		s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
		s.rate_x = 16'(rx); s.rate_y = 16'(ry); s.rate_z = 16'(rx ^ ry);
		s.step_us = 16'(st);
		return s;
	endfunction

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				send(rand_sample($urandom_range(0, 3) != 0));
				burst--; n--;
			end
			if ($urandom_range(0, 2) != 0) pause_gap();
		end
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: extremes, zero vector, negative x direction, step hold.
		send(mk(0, 0, 0, 0, 0, 0));
		send(mk(0, 0, 2509, 100, -100, 0));
		send(mk(0, 0, -2509, 32767, 32767, 65535));
		send(mk(0, 0, -2509, 32767, 32767, 0));
		send(mk(0, -2509, 0, -32768, -32768, 65535));
		send(mk(2509, 0, 0, -32768, -32768, 0));
		send(mk(-2509, 0, 0, 0, 0, 1));
		send(mk(-32768, -32768, -32768, 1, -1, 0));
		send(mk(32767, 32767, 32767, -1, 1, 65535));
		send(mk(1774, 1774, 0, 5, 5, 100));
		send(mk(0, 2381, 0, 0, 0, 0));
		send(mk(0, 2637, 0, 0, 0, 0));
		for (int i = 0; i < 8; i++) send(mk(0, 0, 2509, 32767, 32767, 65535));
		for (int i = 0; i < 8; i++) send(mk(0, 0, 2509, -32768, -32768, 65535));
		drain();

		random_phase(350);
		drain();

		// Extreme settings: gyro weight zero, step zero, lower band bound below zero.
		write_reg(CFG_BLEND_GAIN, 16'd0);
		write_reg(CFG_INITIAL_STEP, 16'd0);
		write_reg(CFG_GRAVITY_BAND, 16'd32767);
		write_reg(CFG_GRAVITY_LEVEL, 16'd0);
		send(mk(0, 0, 0, 500, 500, 0));
		send(mk(10, 20, 30, 500, 500, 0));
		random_phase(300);
		drain();

		write_reg(CFG_BLEND_GAIN, 16'd65535);
		write_reg(CFG_INITIAL_STEP, 16'd65535);
		write_reg(CFG_GRAVITY_LEVEL, 16'd32767);
		write_reg(CFG_GRAVITY_BAND, 16'd0);
		random_phase(300);
		drain();

		write_reg(CFG_BLEND_GAIN, 16'd32768);
		write_reg(CFG_INITIAL_STEP, 16'd1);
		write_reg(CFG_GRAVITY_LEVEL, 16'd2509);
		write_reg(CFG_GRAVITY_BAND, 16'd600);
		random_phase(300);
		drain();

		write_reg(CFG_BLEND_GAIN, 16'($urandom));
		write_reg(CFG_INITIAL_STEP, 16'($urandom_range(1, 65535)));
		write_reg(CFG_GRAVITY_LEVEL, 16'($urandom_range(2000, 3000)));
		write_reg(CFG_GRAVITY_BAND, 16'($urandom_range(0, 1000)));
		random_phase(330);
		drain();

		$display("sent %0d samples over five register settings, %0d results blended",
			sent, blended_count);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/ctf_pkg.sv
rtl/ctf_mul.sv
rtl/ctf_div.sv
rtl/ctf_sqrt.sv
rtl/ctf_cordic.sv
rtl/imu_tilt_complementary_filter_unit.sv
rtl/ctf_checker.sv
tb/ctf_checker.sv
tb/tb_imu_tilt_complementary_filter_unit.sv
